// ----- hdl/nlp_pkg.sv -----
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the next lexicographic permutation block.
// ----------------------------------------------------------------------------
package nlp_pkg;

   localparam int SYM_W       = 8;
   localparam int NUM_SYM     = 8;
   localparam int WORD_W      = SYM_W * NUM_SYM;
   localparam int IDX_W       = $clog2(NUM_SYM);
   localparam int LEN_W       = 4;
   localparam int MAX_LEN_DEF = 8;

   typedef struct packed {
      logic [WORD_W-1:0] letters;
      logic [LEN_W-1:0]  word_length;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] next_letters;
      logic              already_last;
   } rsp_type;

endpackage

// ----- hdl/next_lexicographic_permutation_top.sv -----
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_top
// Four-stage pipeline that returns the next permutation of a packed word.
// ----------------------------------------------------------------------------
// A transaction is accepted on every clock edge at which start is high; busy
// is never raised, so one word may enter in every cycle and the block
// sustains one result per cycle. Each result appears on rsp_payload once it
// has passed all the register stages, marked by rsp_strobe for one cycle.
// The receiver cannot stall the block, and none is needed: the four
// register stages (rise detection, pivot selection, successor selection,
// swap and suffix reversal) move in lockstep and every transaction leaves
// in the order it arrived. Lengths above MAX_LEN are clamped to MAX_LEN.
// Words of length zero or one, and words with no rise, come back unchanged
// with already_last set. Bytes at or beyond the length pass through as is.
module next_lexicographic_permutation_top #(
   parameter int MAX_LEN = nlp_pkg::MAX_LEN_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  nlp_pkg::req_type req_payload,
   output logic            rsp_strobe,
   output nlp_pkg::rsp_type rsp_payload
);
   import nlp_pkg::*;

   // The pipeline never needs to hold off the requester.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------
   // Stage 1: clamp the length and flag every rise sym[k] < sym[k+1] that
   // lies inside the word.
   // ---------------------------------------------------------------------
   logic                 s1_vld_ff;
   logic [WORD_W-1:0]    s1_word_ff;
   logic [LEN_W-1:0]     s1_len_ff;
   logic [NUM_SYM-2:0]   s1_rise_ff;
   logic [LEN_W-1:0]     s1_len_in;
   logic [NUM_SYM-2:0]   s1_rise_in;

   always_comb begin
      if (req_payload.word_length > LEN_W'(MAX_LEN)) begin
         s1_len_in = LEN_W'(MAX_LEN);
      end else begin
         s1_len_in = req_payload.word_length;
      end
      for (int k = 0; k < NUM_SYM - 1; k++) begin
         s1_rise_in[k] = (LEN_W'(k + 1) < s1_len_in) &&
                         (req_payload.letters[k*SYM_W +: SYM_W] <
                          req_payload.letters[(k+1)*SYM_W +: SYM_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_word_ff <= req_payload.letters;
      s1_len_ff  <= s1_len_in;
      s1_rise_ff <= s1_rise_in;
   end

   // ---------------------------------------------------------------------
   // Stage 2: the pivot is the rightmost rise; fetch its symbol.
   // ---------------------------------------------------------------------
   logic                 s2_vld_ff;
   logic [WORD_W-1:0]    s2_word_ff;
   logic [LEN_W-1:0]     s2_len_ff;
   logic                 s2_found_ff;
   logic [IDX_W-1:0]     s2_piv_ff;
   logic [SYM_W-1:0]     s2_pivsym_ff;
   logic [IDX_W-1:0]     s2_piv_in;
   logic [SYM_W-1:0]     s2_pivsym_in;

   always_comb begin
      s2_piv_in = '0;
      for (int k = 0; k < NUM_SYM - 1; k++) begin
         if (s1_rise_ff[k]) begin
            s2_piv_in = IDX_W'(k);
         end
      end
      s2_pivsym_in = s1_word_ff[s2_piv_in*SYM_W +: SYM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_word_ff   <= s1_word_ff;
      s2_len_ff    <= s1_len_ff;
      s2_found_ff  <= |s1_rise_ff;
      s2_piv_ff    <= s2_piv_in;
      s2_pivsym_ff <= s2_pivsym_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: the suffix after the pivot is non-increasing, so the
   // rightmost symbol in it that exceeds the pivot is the smallest one.
   // ---------------------------------------------------------------------
   logic                 s3_vld_ff;
   logic [WORD_W-1:0]    s3_word_ff;
   logic [LEN_W-1:0]     s3_len_ff;
   logic                 s3_found_ff;
   logic [IDX_W-1:0]     s3_piv_ff;
   logic [SYM_W-1:0]     s3_pivsym_ff;
   logic [IDX_W-1:0]     s3_pick_ff;
   logic [IDX_W-1:0]     s3_pick_in;

   always_comb begin
      s3_pick_in = '0;
      for (int k = 1; k < NUM_SYM; k++) begin
         if ((IDX_W'(k) > s2_piv_ff) && (LEN_W'(k) < s2_len_ff) &&
             (s2_word_ff[k*SYM_W +: SYM_W] > s2_pivsym_ff)) begin
            s3_pick_in = IDX_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_word_ff   <= s2_word_ff;
      s3_len_ff    <= s2_len_ff;
      s3_found_ff  <= s2_found_ff;
      s3_piv_ff    <= s2_piv_ff;
      s3_pivsym_ff <= s2_pivsym_ff;
      s3_pick_ff   <= s3_pick_in;
   end

   // ---------------------------------------------------------------------
   // Stage 4: swap pivot and successor, then reverse the suffix. The
   // suffix stays non-increasing after the swap, so reversing it sorts it.
   // ---------------------------------------------------------------------
   logic                 rsp_vld_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic [SYM_W-1:0]     sym [NUM_SYM];
   logic [LEN_W-1:0]     src_full;
   logic [IDX_W-1:0]     src;

   always_comb begin
      src_full = '0;
      src      = '0;
      for (int k = 0; k < NUM_SYM; k++) begin
         sym[k] = s3_word_ff[k*SYM_W +: SYM_W];
      end
      rsp_in.next_letters = s3_word_ff;
      rsp_in.already_last = !s3_found_ff;
      if (s3_found_ff) begin
         rsp_in.next_letters[s3_piv_ff*SYM_W +: SYM_W] = sym[s3_pick_ff];
         for (int i = 1; i < NUM_SYM; i++) begin
            if ((IDX_W'(i) > s3_piv_ff) && (LEN_W'(i) < s3_len_ff)) begin
               src_full = LEN_W'(s3_piv_ff) + s3_len_ff - LEN_W'(i);
               src      = src_full[IDX_W-1:0];
               if (src == s3_pick_ff) begin
                  rsp_in.next_letters[i*SYM_W +: SYM_W] = s3_pivsym_ff;
               end else begin
                  rsp_in.next_letters[i*SYM_W +: SYM_W] = sym[src];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= s3_vld_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Every accepted transaction produces its result strobe once it has passed through the pipeline.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("result strobe missing four cycles after a request");

   // A word flagged as last comes back unchanged.
   a_last_unchanged : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(accept, 4) && rsp_payload.already_last) |->
      (rsp_payload.next_letters == $past(req_payload.letters, 4)))
      else $error("word flagged as last was modified");

   // A real successor always differs from the word it came from.
   a_next_differs : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(accept, 4) && !rsp_payload.already_last) |->
      (rsp_payload.next_letters != $past(req_payload.letters, 4)))
      else $error("successor equals its input word");

   // Words shorter than two symbols have no successor.
   a_short_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(accept, 4) &&
       ($past(req_payload.word_length, 4) < LEN_W'(2))) |->
      rsp_payload.already_last)
      else $error("short word not flagged as last");

endmodule
